// File: design/jsu_pkg.sv
// shared types, codes and helper functions of the json string unescaper
`default_nettype none

package jsu_pkg;

  // default width of the decoded length counter
  localparam int unsigned LengthBitsDefault = 16;
  // default depth of the job queue between front and back
  localparam int unsigned QueueDepthDefault = 2;
  // width of the reported length field
  localparam int unsigned RepLenBits = 16;

  // result kinds
  localparam logic [3:0] KindData      = 4'd0;
  localparam logic [3:0] KindQuoteEnd  = 4'd1;
  localparam logic [3:0] KindZeroEnd   = 4'd2;
  localparam logic [3:0] KindNoOpen    = 4'd3;
  localparam logic [3:0] KindCtrl      = 4'd4;
  localparam logic [3:0] KindBadEsc    = 4'd5;
  localparam logic [3:0] KindBadHex    = 4'd6;
  localparam logic [3:0] KindNoLow     = 4'd7;
  localparam logic [3:0] KindBadLow    = 4'd8;

  // source characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;

  // one accepted byte's worth of results, 1 to 4 beats
  typedef struct packed {
    logic [1:0]            n_m1;     // beats minus one
    logic [3:0]            kind;
    logic [3:0][7:0]       bytes;    // bytes[0] leaves first
    logic [RepLenBits-1:0] len;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]      n_m1;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t e;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.n_m1     = 2'd0;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.n_m1     = 2'd1;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n_m1     = 2'd2;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.n_m1     = 2'd3;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/jsu_in_if.sv
// source byte channel
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: design/jsu_out_if.sv
// decoded result channel
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  out_byte;
  logic        run_last;
  logic [15:0] decoded_length;

  modport source (output valid, output kind, output out_byte, output run_last,
                  output decoded_length, input ready);
  modport sink (input valid, input kind, input out_byte, input run_last,
                input decoded_length, output ready);
endinterface

`default_nettype wire

// File: design/json_string_unescape_utf8_core.sv
// top level of the json string unescaper with utf-8 output
`default_nettype none

// Decodes one JSON string literal per run, one source byte per beat on in_i,
// starting at the opening quote, and gives UTF-8 bytes and end or error beats
// on out_o. The front parser takes one source byte every cycle while the job
// queue has room; each byte that causes results pushes one job of 1 to 4 beats.
// The back drains jobs at one beat per cycle while the sink is ready, through a
// registered output stage, so a \u escape whose code point needs k UTF-8 bytes
// gives k output beats; since such an escape spends at least six source bytes,
// sustained input keeps one byte per cycle while the sink is ready. An accepted
// byte's first result beat is registered in the job queue, then in the output
// stage. A closing quote or a zero byte reports the decoded length (saturating);
// any error reports its kind and the block goes back to await an opening quote.
module json_string_unescape_utf8_core #(
  parameter int unsigned LENGTH_BITS = jsu_pkg::LengthBitsDefault,
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // jobs between parser and output stage
  logic full;
  logic empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  // parser: phase, hex digits, surrogate units and the running length
  jsu_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .job_o (push_job)
  );

  // decouples parsing from output stalls
  jsu_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (full),
    .empty_o(empty),
    .pop_i  (pop),
    .job_o  (head_job)
  );

  // one result beat per cycle, held while the sink stalls
  jsu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .job_i  (head_job),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: design/jsu_front.sv
// parser front: accepts source bytes, tracks escape state, builds result jobs
`default_nettype none

module jsu_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  jsu_in_if.sink             in_i,
  input  wire logic          full_i,
  output logic               push_o,
  output jsu_pkg::job_t      job_o
);
  import jsu_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhStr  = 3'd1;
  localparam logic [2:0] PhEsc  = 3'd2;
  localparam logic [2:0] PhHex1 = 3'd3;
  localparam logic [2:0] PhBsl  = 3'd4;
  localparam logic [2:0] PhLowU = 3'd5;
  localparam logic [2:0] PhHex2 = 3'd6;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic [2:0]             phase_q, phase_d;
  logic [1:0]             hex_cnt_q, hex_cnt_d;
  logic [15:0]            unit1_q, unit1_d;
  logic [15:0]            unit2_q, unit2_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS:0]   len_sum;
  logic [2:0]             len_add;
  logic                   len_clr;
  logic [RepLenBits-1:0]  len_rep;
  logic                   fire;
  logic                   emit;
  job_t                   job;
  hex_t                   hv;
  logic [15:0]            u1_new, u2_new;
  utf8_t                  enc;
  logic [7:0]             c;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && !full_i;
  assign c          = in_i.in_byte;

  // reported length saturates at the field maximum
  if (LENGTH_BITS > RepLenBits) begin : g_len_wide
    assign len_rep = (|len_q[LENGTH_BITS-1:RepLenBits]) ? '1 : len_q[RepLenBits-1:0];
  end else if (LENGTH_BITS == RepLenBits) begin : g_len_same
    assign len_rep = len_q;
  end else begin : g_len_narrow
    assign len_rep = {{(RepLenBits-LENGTH_BITS){1'b0}}, len_q};
  end

  assign hv     = hex_decode(c);
  assign u1_new = {unit1_q[11:0], hv.val};
  assign u2_new = {unit2_q[11:0], hv.val};

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    unit1_d   = unit1_q;
    unit2_d   = unit2_q;
    len_add   = 3'd0;
    len_clr   = 1'b0;
    emit      = 1'b0;
    job       = '0;
    enc       = '0;
    unique case (phase_q)
      PhIdle: begin
        if (c == ChQuote) begin
          phase_d = PhStr;
          len_clr = 1'b1;
        end else begin
          emit     = 1'b1;
          job.kind = KindNoOpen;
        end
      end
      PhStr: begin
        if (c == 8'h00) begin
          emit     = 1'b1;
          job.kind = KindZeroEnd;
          job.len  = len_rep;
          phase_d  = PhIdle;
        end else if (c < ChSpace) begin
          emit     = 1'b1;
          job.kind = KindCtrl;
          phase_d  = PhIdle;
        end else if (c == ChBslash) begin
          phase_d = PhEsc;
        end else if (c == ChQuote) begin
          emit     = 1'b1;
          job.kind = KindQuoteEnd;
          job.len  = len_rep;
          phase_d  = PhIdle;
        end else begin
          emit         = 1'b1;
          job.bytes[0] = c;
          len_add      = 3'd1;
        end
      end
      PhEsc: begin
        phase_d      = PhStr;
        emit         = 1'b1;
        len_add      = 3'd1;
        unique case (c)
          ChQuote, ChBslash, ChSlash: job.bytes[0] = c;
          ChLowB: job.bytes[0] = 8'h08;
          ChLowF: job.bytes[0] = 8'h0C;
          ChLowN: job.bytes[0] = 8'h0A;
          ChLowR: job.bytes[0] = 8'h0D;
          ChLowT: job.bytes[0] = 8'h09;
          ChLowU: begin
            emit      = 1'b0;
            len_add   = 3'd0;
            phase_d   = PhHex1;
            hex_cnt_d = 2'd0;
            unit1_d   = '0;
          end
          default: begin
            len_add  = 3'd0;
            job.kind = KindBadEsc;
            phase_d  = PhIdle;
          end
        endcase
      end
      PhHex1: begin
        if (!hv.ok) begin
          emit     = 1'b1;
          job.kind = KindBadHex;
          phase_d  = PhIdle;
        end else begin
          unit1_d = u1_new;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = 2'd0;
            if (u1_new[15:10] == 6'b110110) begin
              // high surrogate, a low one must follow
              phase_d = PhBsl;
            end else begin
              enc       = utf8_encode({5'd0, u1_new});
              emit      = 1'b1;
              job.n_m1  = enc.n_m1;
              job.bytes = enc.bytes;
              len_add   = {1'b0, enc.n_m1} + 3'd1;
              phase_d   = PhStr;
            end
          end
        end
      end
      PhBsl: begin
        if (c == ChBslash) begin
          phase_d = PhLowU;
        end else begin
          emit     = 1'b1;
          job.kind = KindNoLow;
          phase_d  = PhIdle;
        end
      end
      PhLowU: begin
        if (c == ChLowU) begin
          phase_d   = PhHex2;
          hex_cnt_d = 2'd0;
          unit2_d   = '0;
        end else begin
          emit     = 1'b1;
          job.kind = KindNoLow;
          phase_d  = PhIdle;
        end
      end
      PhHex2: begin
        if (!hv.ok) begin
          emit     = 1'b1;
          job.kind = KindBadHex;
          phase_d  = PhIdle;
        end else begin
          unit2_d = u2_new;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = 2'd0;
            if (u2_new[15:10] != 6'b110111) begin
              emit     = 1'b1;
              job.kind = KindBadLow;
              phase_d  = PhIdle;
            end else begin
              enc       = utf8_encode({1'b0, unit1_q[9:0], u2_new[9:0]} + 21'h10000);
              emit      = 1'b1;
              job.n_m1  = enc.n_m1;
              job.bytes = enc.bytes;
              len_add   = {1'b0, enc.n_m1} + 3'd1;
              phase_d   = PhStr;
            end
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // saturating length add, at most four per byte
  assign len_sum = {1'b0, len_q} + (LENGTH_BITS+1)'(len_add);
  always_comb begin
    if (len_clr) begin
      len_d = '0;
    end else if (len_sum[LENGTH_BITS]) begin
      len_d = LenMax;
    end else begin
      len_d = len_sum[LENGTH_BITS-1:0];
    end
  end

  assign push_o = fire && emit;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hex_cnt_q <= 2'd0;
      unit1_q   <= '0;
      unit2_q   <= '0;
      len_q     <= '0;
    end else if (fire) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      unit1_q   <= unit1_d;
      unit2_q   <= unit2_d;
      len_q     <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: design/jsu_fifo.sv
// short job queue between parser front and output back
`default_nettype none

module jsu_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jsu_pkg::job_t job_i,
  output logic               full_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output jsu_pkg::job_t      job_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  job_t               mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/jsu_back.sv
// output back: walks each job one beat at a time into the output register
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire jsu_pkg::job_t job_i,
  output logic               pop_o,
  jsu_out_if.source          out_o
);
  import jsu_pkg::*;

  logic                  valid_q;
  logic [3:0]            kind_q;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic [RepLenBits-1:0] len_q;
  logic [1:0]            idx_q;
  logic                  load;
  logic                  take;
  logic                  is_last;

  assign load    = !valid_q || out_o.ready;
  assign take    = load && !empty_i;
  assign is_last = (idx_q == job_i.n_m1);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (take) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= job_i.kind;
      byte_q <= job_i.bytes[idx_q];
      last_q <= is_last;
      len_q  <= job_i.len;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.run_last       = last_q;
  assign out_o.decoded_length = len_q;

endmodule

`default_nettype wire
